### design/sai_pkg.sv
// ----------------------------------------------------------------------------
// sai_pkg: shared types and constants of the strided access interval unit
// Holds the item and result layouts that the channel interfaces carry.
// ----------------------------------------------------------------------------
package sai_pkg;

  localparam logic [63:0] MOST_NEGATIVE_64 = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic               term_valid;
    logic signed [63:0] term_stride;
    logic               term_has_values;
    logic               last_term;
    logic [15:0]        lane_count;
    logic signed [63:0] lane_stride;
    logic [15:0]        element_bytes;
    logic signed [63:0] static_offset;
  } item_t;

  typedef struct packed {
    logic               envelope_ok;
    logic signed [63:0] lane_begin;
    logic [62:0]        lane_end;
    logic               strided_ok;
    logic [62:0]        interval_stride;
    logic [62:0]        interval_begin;
    logic [62:0]        interval_end;
  } result_t;

endpackage

### design/sai_item_if.sv
// ----------------------------------------------------------------------------
// sai_item_if: input item channel
// Valid/ready channel carrying one stride term and the plan fields.
// ----------------------------------------------------------------------------
interface sai_item_if;
  import sai_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/sai_result_if.sv
// ----------------------------------------------------------------------------
// sai_result_if: result channel
// Valid/ready channel carrying the envelope and the periodic interval.
// ----------------------------------------------------------------------------
interface sai_result_if;
  import sai_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/strided_access_interval_unit.sv
// ----------------------------------------------------------------------------
// strided_access_interval_unit: periodic byte interval of a strided access
// Running GCD of term strides, checked lane envelope and residue fit.
// ----------------------------------------------------------------------------
// Each input beat carries one dynamic stride term; the beat with last_term
// set also carries the plan and produces exactly one result beat. The long
// work goes one step per cycle: a term folds into the running GCD by the
// binary GCD method, the last lane offset is formed by shift-and-add over
// the 16 bits of the lane count, and the residue of the access begin modulo
// the stride comes from restoring division; one shared 64-bit subtract
// serves the GCD and the division. The unit is not ready while a beat is
// being worked on. A finished result waits in its output register and a new
// input beat is taken meanwhile; the next last beat holds in its final step
// until that register has been emptied.
module strided_access_interval_unit (
  input logic   clk,
  input logic   rst,
  sai_item_if.sink     in_item,
  sai_result_if.source out_result
);
  import sai_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_GCD_SHIFT, S_GCD_STEP, S_GCD_DONE, S_MUL, S_ENV,
    S_ADDR, S_DIV, S_FIT
  } state_t;

  state_t      state;
  item_t       item;
  logic [63:0] running_gcd;
  logic        term_failed;
  logic        term_seen;
  // Shared working registers.
  logic [63:0] ga, gb;
  logic [6:0]  gshift;
  logic [63:0] acc;      // product magnitude / remainder
  logic [63:0] mcand;    // multiplicand / dividend-shift register
  logic [15:0] mcount;   // remaining multiplier bits
  logic [6:0]  step;
  logic        ovf;
  logic [63:0] lbeg, lend, ab, len;
  logic        env_ok;
  result_t     res;
  logic        res_valid;
  logic        res_load;

  // Shared subtract: a single 65-bit difference used by the GCD and division phases.
  logic [63:0] sub_a, sub_b;
  logic [64:0] sub_d;
  assign sub_d = {1'b0, sub_a} - {1'b0, sub_b};

  logic [63:0] tmag, smag, absab;
  logic        sneg;
  logic [64:0] sum_top, rem_sh;
  assign tmag   = item.term_stride[63] ? 64'(-item.term_stride) : item.term_stride;
  assign sneg   = item.lane_stride[63];
  assign smag   = sneg ? 64'(-item.lane_stride) : item.lane_stride;
  assign absab  = ab[63] ? 64'(-ab) : ab;
  assign rem_sh = {acc, mcand[63]};

  always_comb begin
    sub_a = ga;
    sub_b = gb;
    case (state)
      S_DIV: begin
        sub_a = rem_sh[63:0];
        sub_b = running_gcd;
      end
      default: begin
        sub_a = ga;
        sub_b = gb;
      end
    endcase
  end

  logic [64:0] ab_sum, ae_sum;
  logic        ab_ovf, ae_ovf;
  logic [63:0] ae;
  assign ab_sum = {1'b0, item.static_offset} + {1'b0, lbeg};
  assign ae_sum = {1'b0, item.static_offset} + {1'b0, lend};
  assign ab_ovf = (item.static_offset[63] == lbeg[63]) && (ab_sum[63] != lbeg[63]);
  assign ae_ovf = (item.static_offset[63] == lend[63]) && (ae_sum[63] != lend[63]);
  assign ae     = ae_sum[63:0];
  assign sum_top = {1'b0, acc} + {49'd0, item.element_bytes};
  logic [63:0] s_minus_len;
  assign s_minus_len = running_gcd - len;

  // The finished result enters the output register only once it is free.
  assign res_load = (state == S_FIT) && (!res_valid || out_result.ready);

  assign in_item.ready    = (state == S_IDLE);
  assign out_result.valid = res_valid;
  assign out_result.data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      running_gcd <= '0;
      term_failed <= 1'b0;
      term_seen   <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (res_load) res_valid <= 1'b1;
      else if (out_result.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_item.valid) begin
          item  <= in_item.data;
          state <= S_GCD_SHIFT;
          ga    <= running_gcd;
          gshift <= '0;
        end
        S_GCD_SHIFT: begin
          // Load the operands of the GCD fold, or skip it.
          state <= S_GCD_DONE;
          if (item.term_valid) begin
            term_seen <= 1'b1;
            if (item.term_has_values || item.term_stride == 64'd0 ||
                item.term_stride == MOST_NEGATIVE_64) begin
              term_failed <= 1'b1;
            end else if (running_gcd == 64'd0) begin
              running_gcd <= tmag;
            end else begin
              ga <= running_gcd;
              gb <= tmag;
              gshift <= '0;
              state <= S_GCD_STEP;
            end
          end
        end
        S_GCD_STEP: begin
          // Binary GCD: one shift or one subtract-and-shift per cycle.
          if (ga == gb) begin
            running_gcd <= ga << gshift;
            state <= S_GCD_DONE;
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1; gb <= gb >> 1; gshift <= gshift + 7'd1;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (!sub_d[64]) begin
            ga <= sub_d[63:0] >> 1;
          end else begin
            gb <= (gb - ga) >> 1;
          end
        end
        S_GCD_DONE: begin
          if (!item.last_term) begin
            state <= S_IDLE;
          end else begin
            acc    <= '0;
            ovf    <= 1'b0;
            mcand  <= smag;
            mcount <= item.lane_count - 16'd1;
            step   <= '0;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          // Shift-and-add, most significant multiplier bit first; any carry
          // beyond 64 bits marks overflow.
          if (step == 7'd16) begin
            state <= S_ENV;
          end else begin
            logic [65:0] t;
            t = {1'b0, acc, 1'b0} + (mcount[15] ? {2'b0, mcand} : 66'd0);
            if (acc[63] || t[65:64] != 2'b0) ovf <= 1'b1;
            acc    <= t[63:0];
            mcount <= mcount << 1;
            step   <= step + 7'd1;
          end
        end
        S_ENV: begin
          env_ok <= 1'b0;
          lbeg   <= '0;
          lend   <= '0;
          if (item.lane_count != 16'd0 && item.element_bytes != 16'd0 && !ovf &&
              (sneg ? acc <= MOST_NEGATIVE_64 : acc[63] == 1'b0)) begin
            if (sneg) begin
              env_ok <= 1'b1;
              lbeg   <= 64'(-acc);
              lend   <= {48'd0, item.element_bytes};
            end else if (!sum_top[63]) begin
              env_ok <= 1'b1;
              lbeg   <= '0;
              lend   <= sum_top[63:0];
            end
          end
          state <= S_ADDR;
        end
        S_ADDR: begin
          ab  <= ab_sum[63:0];
          len <= ae - ab_sum[63:0];
          ovf <= ab_ovf || ae_ovf || ($signed(ae) <= $signed(ab_sum[63:0]));
          state <= S_DIV;
          acc   <= '0;
          mcand <= '0;
          step  <= '0;
        end
        S_DIV: begin
          // Restoring division of |ab| by the stride, one bit per cycle.
          if (step == 7'd0 && mcand == 64'd0) mcand <= absab;
          if (step == 7'd65) begin
            state <= S_FIT;
          end else if (step != 7'd0) begin
            acc   <= sub_d[64] ? rem_sh[63:0] : sub_d[63:0];
            mcand <= mcand << 1;
          end
          if (!(step == 7'd0 && mcand == 64'd0) || step != 7'd0)
            step <= step + 7'd1;
          if (step == 7'd0 && mcand == 64'd0) step <= 7'd1;
        end
        S_FIT: if (res_load) begin
          logic [63:0] b;
          logic        ok;
          b = (ab[63] && acc != 64'd0) ? running_gcd - acc : acc;
          ok = env_ok && term_seen && !term_failed && running_gcd != 64'd0 &&
               !ovf && !len[63] && len != 64'd0 && len <= running_gcd &&
               b <= s_minus_len;
          res.envelope_ok     <= env_ok;
          res.lane_begin      <= lbeg;
          res.lane_end        <= lend[62:0];
          res.strided_ok      <= ok;
          res.interval_stride <= ok ? running_gcd[62:0] : 63'd0;
          res.interval_begin  <= ok ? b[62:0] : 63'd0;
          res.interval_end    <= ok ? 63'(b + len) : 63'd0;
          running_gcd <= '0;
          term_failed <= 1'b0;
          term_seen   <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Assertions.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_item.ready) else $error("ready while busy");
  a_stride_ok: assert property (@(posedge clk) disable iff (rst)
    (out_result.valid && out_result.data.strided_ok) |->
      (out_result.data.interval_stride != 63'd0 && out_result.data.envelope_ok))
    else $error("interval without envelope");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_result.valid && !out_result.ready) |=> $stable(out_result.data))
    else $error("result changed while stalled");

endmodule
